// File: rtl/core/slh_pkg.sv
package slh_pkg;

    // Default depth of the event history.
    localparam int DEF_HISTORY_DEPTH = 5;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int RAW_W   = 13;
    localparam int LEVEL_W = 8;
    localparam int EVENT_W = 2;
    localparam int PROD_W  = RAW_W + LEVEL_W;

    // The level is raw * 255 / 8191, where 8191 is the ADC full scale.
    localparam int ADC_FULL_SCALE = (2 ** RAW_W) - 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_QUIET = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LOUD  = 2'd2;

    // Configuration registers.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_QUIET_THR = 1'b0;
    localparam logic REG_LOUD_THR  = 1'b1;
    localparam logic [LEVEL_W-1:0] QUIET_THR_RST = 8'd127;
    localparam logic [LEVEL_W-1:0] LOUD_THR_RST  = 8'd126;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCALE,
        ST_PUSH_QUIET,
        ST_PUSH_LOUD,
        ST_SAMPLE_OUT,
        ST_CHECK_SCAN,
        ST_CHECK_OUT,
        ST_DRAIN
    } slh_state_t;

    typedef enum logic [1:0] {
        EMIT_SAMPLE,
        EMIT_CHECK,
        EMIT_DRAIN,
        EMIT_DRAIN_EMPTY
    } slh_emit_t;

    typedef struct packed {
        logic      latch_in;
        logic      calc_prod;
        logic      calc_level;
        logic      push_quiet;
        logic      push_loud;
        logic      idx_clear;
        logic      idx_inc;
        logic      found_acc;
        logic      emit;
        slh_emit_t emit_kind;
        logic      clear_hist;
    } slh_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_free;
        logic            count_zero;
        logic            idx_at_count;
        logic            idx_last;
        logic            below_quiet;
        logic            above_loud;
    } slh_status_t;

endpackage

// File: rtl/core/sound_level_event_history.sv
// Sound level event history. Each input transaction carries one operation.
// A sample scales a 13-bit ADC reading to an 8-bit level (raw * 255 / 8191,
// truncated), pushes QUIET when the level is below quiet_threshold and then
// LOUD when it is above loud_threshold, and returns the level with the newest
// stored event. A push equal to the newest entry is dropped, and a full
// history shifts out its oldest entry. A check reports whether target_event
// is stored (for target none: whether the history is not yet full) and then
// clears the history. A drain returns every stored entry oldest first, one
// output transaction each with last_item on the newest, or a single empty
// result when nothing is stored, and then clears. Operation code 3 is taken
// and ignored. Items are processed one at a time by a controller stepping a
// datapath: a sample passes through decode, scale, the quiet push, the loud
// push and the output state; a check decodes, scans the stored entries and
// then emits; a drain decodes and then returns its results (an empty history
// still returns one). The history is read one entry per cycle, though a drain
// pauses while its previous result still waits on out_stall. Finished results
// sit in an output register, so the next input transaction is taken while a
// result still waits on out_stall. The two thresholds sit at byte addresses 0
// and 4 of the APB port and should be written only while the block is idle.
module sound_level_event_history
    import slh_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [RAW_W-1:0]      raw_sample,
    input  logic [EVENT_W-1:0]    target_event,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_W-1:0]    sound_level,
    output logic [EVENT_W-1:0]    current_event,
    output logic                  event_found,
    output logic [EVENT_W-1:0]    drained_event,
    output logic                  last_item
);

    logic [LEVEL_W-1:0] quiet_thr_reg, quiet_thr_next;
    logic [LEVEL_W-1:0] loud_thr_reg,  loud_thr_next;
    logic               cfg_write;
    logic               reg_sel;
    slh_cmd_t           cmd;
    slh_status_t        stat;

    // The register index is the word address; pready is always high, so
    // a write completes in its access cycle.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        quiet_thr_next = quiet_thr_reg;
        loud_thr_next  = loud_thr_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_QUIET_THR: quiet_thr_next = pwdata[LEVEL_W-1:0];
                REG_LOUD_THR:  loud_thr_next  = pwdata[LEVEL_W-1:0];
                default:       quiet_thr_next = quiet_thr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_QUIET_THR: prdata = CFG_DATA_W'(quiet_thr_reg);
            REG_LOUD_THR:  prdata = CFG_DATA_W'(loud_thr_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_thr_reg <= QUIET_THR_RST;
            loud_thr_reg  <= LOUD_THR_RST;
        end
        else
        begin
            quiet_thr_reg <= quiet_thr_next;
            loud_thr_reg  <= loud_thr_next;
        end
    end

    // The controller sequences each operation; the datapath holds the
    // history, the level arithmetic and the output register.
    slh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    slh_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .raw_sample    (raw_sample),
        .target_event  (target_event),
        .quiet_thr     (quiet_thr_reg),
        .loud_thr      (loud_thr_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sound_level   (sound_level),
        .current_event (current_event),
        .event_found   (event_found),
        .drained_event (drained_event),
        .last_item     (last_item)
    );

`ifndef SYNTHESIS
    // Once a transaction is taken, the block is busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while the previous item was still decoding");

    // Only one kind of field is live in any result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((sound_level == '0 && current_event == EV_NONE)
                       || (!event_found && drained_event == EV_NONE)))
        else $error("result mixes sample fields with check or drain fields");

    // A result is only loaded into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over one still waiting");
`endif

endmodule

// File: rtl/core/slh_ctrl.sv
module slh_ctrl
    import slh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  slh_status_t stat,
    output slh_cmd_t    cmd
);

    slh_state_t state_reg;
    slh_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_kind = EMIT_SAMPLE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.op)
                    OP_SAMPLE:
                    begin
                        cmd.calc_prod = 1'b1;
                        state_next    = ST_SCALE;
                    end
                    OP_CHECK:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_CHECK_SCAN;
                    end
                    OP_DRAIN:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_DRAIN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCALE:
            begin
                cmd.calc_level = 1'b1;
                state_next     = ST_PUSH_QUIET;
            end
            ST_PUSH_QUIET:
            begin
                cmd.push_quiet = stat.below_quiet;
                state_next     = ST_PUSH_LOUD;
            end
            ST_PUSH_LOUD:
            begin
                cmd.push_loud = stat.above_loud;
                state_next    = ST_SAMPLE_OUT;
            end
            ST_SAMPLE_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_SAMPLE;
                    state_next    = ST_IDLE;
                end
            end
            ST_CHECK_SCAN:
            begin
                if (stat.idx_at_count)
                begin
                    state_next = ST_CHECK_OUT;
                end
                else
                begin
                    cmd.found_acc = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            ST_CHECK_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = EMIT_CHECK;
                    cmd.clear_hist = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.count_zero)
                    begin
                        cmd.emit_kind  = EMIT_DRAIN_EMPTY;
                        cmd.clear_hist = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (stat.idx_last)
                    begin
                        cmd.emit_kind  = EMIT_DRAIN;
                        cmd.clear_hist = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_kind = EMIT_DRAIN;
                        cmd.idx_inc   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/slh_dp.sv
module slh_dp
    import slh_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  slh_cmd_t           cmd,
    output slh_status_t        stat,
    input  logic [OP_W-1:0]    operation,
    input  logic [RAW_W-1:0]   raw_sample,
    input  logic [EVENT_W-1:0] target_event,
    input  logic [LEVEL_W-1:0] quiet_thr,
    input  logic [LEVEL_W-1:0] loud_thr,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [LEVEL_W-1:0] sound_level,
    output logic [EVENT_W-1:0] current_event,
    output logic               event_found,
    output logic [EVENT_W-1:0] drained_event,
    output logic               last_item
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic [OP_W-1:0]    op_reg,     op_next;
    logic [RAW_W-1:0]   raw_reg,    raw_next;
    logic [EVENT_W-1:0] target_reg, target_next;
    logic [PROD_W-1:0]  prod_reg,   prod_next;
    logic [LEVEL_W-1:0] level_reg,  level_next;
    logic               found_reg,  found_next;
    logic [CW-1:0]      idx_reg,    idx_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [EVENT_W-1:0] store_reg  [HISTORY_DEPTH];
    logic [EVENT_W-1:0] store_next [HISTORY_DEPTH];

    logic               out_valid_reg,   out_valid_next;
    logic [LEVEL_W-1:0] out_level_reg,   out_level_next;
    logic [EVENT_W-1:0] out_current_reg, out_current_next;
    logic               out_found_reg,   out_found_next;
    logic [EVENT_W-1:0] out_drained_reg, out_drained_next;
    logic               out_last_reg,    out_last_next;

    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      idx_p1;
    logic [EVENT_W-1:0] latest;
    logic [EVENT_W-1:0] idx_entry;
    logic               count_zero;
    logic               full;
    logic               push;
    logic [EVENT_W-1:0] push_ev;
    logic [LEVEL_W-1:0] quot_lo;
    logic [RAW_W:0]     rem;
    logic               out_free;

    assign count_m1   = count_reg - 1'b1;
    assign idx_p1     = idx_reg + 1'b1;
    assign count_zero = (count_reg == '0);
    assign full       = (count_reg == CW'(HISTORY_DEPTH));
    assign latest     = store_reg[count_m1[IW-1:0]];
    assign idx_entry  = store_reg[idx_reg[IW-1:0]];
    assign push       = cmd.push_quiet | cmd.push_loud;
    assign push_ev    = cmd.push_quiet ? EV_QUIET : EV_LOUD;
    assign out_free   = !out_valid_reg || !out_stall;

    // Division by 2^13 - 1: the quotient of the top bits plus the low bits
    // leaves a remainder below twice the divisor, so one correction is enough.
    assign quot_lo = prod_reg[PROD_W-1:RAW_W];
    assign rem     = {1'b0, prod_reg[RAW_W-1:0]} + (RAW_W + 1)'(quot_lo);

    always_comb
    begin
        stat              = '0;
        stat.op           = op_reg;
        stat.out_free     = out_free;
        stat.count_zero   = count_zero;
        stat.idx_at_count = (idx_reg == count_reg);
        stat.idx_last     = (idx_p1 == count_reg);
        stat.below_quiet  = (level_reg < quiet_thr);
        stat.above_loud   = (level_reg > loud_thr);
    end

    always_comb
    begin
        op_next     = op_reg;
        raw_next    = raw_reg;
        target_next = target_reg;
        prod_next   = prod_reg;
        level_next  = level_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        store_next  = store_reg;

        if (cmd.latch_in)
        begin
            op_next     = operation;
            raw_next    = raw_sample;
            target_next = target_event;
        end
        // raw * 255 taken as raw * 256 - raw.
        if (cmd.calc_prod)
        begin
            prod_next = {raw_reg, {LEVEL_W{1'b0}}} - PROD_W'(raw_reg);
        end
        if (cmd.calc_level)
        begin
            level_next = quot_lo
                + ((rem >= (RAW_W + 1)'(ADC_FULL_SCALE)) ? 8'd1 : 8'd0);
        end
        if (cmd.idx_clear)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_p1;
        end
        if (cmd.found_acc && (idx_entry == target_reg))
        begin
            found_next = 1'b1;
        end
        // A push equal to the newest entry is dropped; a full history
        // shifts out its oldest entry.
        if (push && !(!count_zero && (latest == push_ev)))
        begin
            if (full)
            begin
                for (int i = 1; i < HISTORY_DEPTH; i++)
                begin
                    store_next[i-1] = store_reg[i];
                end
                store_next[HISTORY_DEPTH-1] = push_ev;
            end
            else
            begin
                store_next[count_reg[IW-1:0]] = push_ev;
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.clear_hist)
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        out_level_next   = out_level_reg;
        out_current_next = out_current_reg;
        out_found_next   = out_found_reg;
        out_drained_next = out_drained_reg;
        out_last_next    = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next   = 1'b1;
            out_level_next   = '0;
            out_current_next = EV_NONE;
            out_found_next   = 1'b0;
            out_drained_next = EV_NONE;
            out_last_next    = 1'b1;
            case (cmd.emit_kind)
                EMIT_SAMPLE:
                begin
                    out_level_next   = level_reg;
                    out_current_next = count_zero ? EV_NONE : latest;
                end
                EMIT_CHECK:
                begin
                    out_found_next = (target_reg == EV_NONE) ? !full : found_reg;
                end
                EMIT_DRAIN:
                begin
                    out_drained_next = idx_entry;
                    out_last_next    = stat.idx_last;
                end
                EMIT_DRAIN_EMPTY:
                begin
                    out_drained_next = EV_NONE;
                end
                default:
                begin
                    out_last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        raw_reg         <= raw_next;
        target_reg      <= target_next;
        prod_reg        <= prod_next;
        level_reg       <= level_next;
        found_reg       <= found_next;
        store_reg       <= store_next;
        out_level_reg   <= out_level_next;
        out_current_reg <= out_current_next;
        out_found_reg   <= out_found_next;
        out_drained_reg <= out_drained_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign sound_level   = out_level_reg;
    assign current_event = out_current_reg;
    assign event_found   = out_found_reg;
    assign drained_event = out_drained_reg;
    assign last_item     = out_last_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the sound level event history block.
// Every input transaction that the block accepts is run through a shadow copy
// of the history, and the results that the shadow produces, or that a typed
// plan row gives, are queued. Each output transaction is then compared,
// field by field, with the oldest entry of that queue.
module testbench;
    import slh_pkg::*;

    // Run shape. The random part is split into phases, one per pair of
    // threshold values, and the history is always idle when a phase begins.
    localparam int RESET_CYCLES    = 10;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam int LEVEL_MAX = (2 ** LEVEL_W) - 1;

    // Codes that the block must accept but that carry no meaning.
    localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
    localparam logic [EVENT_W-1:0] EV_INVALID  = 2'd3;

    // The two thresholds sit one word apart on the register port.
    localparam logic [CFG_ADDR_W-1:0] ADDR_QUIET = {REG_QUIET_THR, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_LOUD  = {REG_LOUD_THR, 2'b00};

    // Threshold pairs for the random phases. The first overlaps, so a sample
    // from level 1 to 254 pushes both events; the second never classifies
    // anything; the last restores the values seen after reset.
    localparam logic [LEVEL_W-1:0] PHASE_QUIET [N_PHASES] = '{255, 0, 200, 100, 1, 127};
    localparam logic [LEVEL_W-1:0] PHASE_LOUD  [N_PHASES] = '{0, 255, 50, 150, 254, 126};

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [EVENT_W-1:0] cur_event;
        logic               found;
        logic [EVENT_W-1:0] drained;
        logic               last;
    } history_result_t;

    typedef enum bit {ROW_ITEM, ROW_WRITE} plan_kind_t;

    // One row of the directed plan. A register write uses addr and wdata
    // only; an item uses op, raw and tgt, and where typed is set the single
    // result it causes is given in the last four columns.
    typedef struct {
        plan_kind_t            kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [LEVEL_W-1:0]    wdata;
        logic [OP_W-1:0]       op;
        logic [RAW_W-1:0]      raw;
        logic [EVENT_W-1:0]    tgt;
        bit                    typed;
        logic [LEVEL_W-1:0]    lvl;
        logic [EVENT_W-1:0]    cur;
        logic                  found;
        logic [EVENT_W-1:0]    drained;
    } plan_row_t;

    // The directed plan starts from the reset thresholds (quiet below 127,
    // loud above 126). It walks the level extremes, a duplicate push being
    // dropped, the history filling up and then shifting out its oldest
    // entry, a full drain, checks for none, an invalid code and quiet held
    // and not held, a drain of an empty history, the unused operation code.
    // It then overlaps the thresholds so that one sample pushes quiet and
    // loud together, and checks for none against a full history.
    localparam int N_ROWS = 27;
    plan_row_t directed_plan [N_ROWS] = '{
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd0,    EV_NONE,    1, 8'd0,   EV_QUIET, 0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd8191, EV_NONE,    1, 8'd255, EV_LOUD,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd4096, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd4050, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd8191, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd1,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd8190, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_DRAIN,  13'd0,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_CHECK,  13'd0,    EV_NONE,    1, 8'd0,   EV_NONE,  1, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_CHECK,  13'd0,    EV_INVALID, 1, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_DRAIN,  13'd0,    EV_NONE,    1, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_UNUSED, 13'd8191, EV_INVALID, 0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd0,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd8191, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_CHECK,  13'd0,    EV_QUIET,   0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd8191, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_CHECK,  13'd0,    EV_QUIET,   0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_WRITE, ADDR_QUIET, 8'd200, OP_SAMPLE, 13'd0,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_WRITE, ADDR_LOUD,  8'd50,  OP_SAMPLE, 13'd0,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd4096, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd4096, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd4096, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_CHECK,  13'd0,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd4096, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_CHECK,  13'd0,    EV_INVALID, 1, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_SAMPLE, 13'd8191, EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE},
        '{ROW_ITEM,  ADDR_QUIET, 8'd0,   OP_DRAIN,  13'd0,    EV_NONE,    0, 8'd0,   EV_NONE,  0, EV_NONE}
    };

    // Every input of the block has a known value from time zero.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation    = OP_SAMPLE;
    logic [RAW_W-1:0]      raw_sample   = '0;
    logic [EVENT_W-1:0]    target_event = EV_NONE;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [LEVEL_W-1:0]    sound_level;
    logic [EVENT_W-1:0]    current_event;
    logic                  event_found;
    logic [EVENT_W-1:0]    drained_event;
    logic                  last_item;

    // Shadow of the block's state and thresholds.
    logic [EVENT_W-1:0] hist_store [DEF_HISTORY_DEPTH];
    int                 hist_count = 0;
    logic [LEVEL_W-1:0] quiet_thr  = QUIET_THR_RST;
    logic [LEVEL_W-1:0] loud_thr   = LOUD_THR_RST;

    // Results that the block still owes, oldest first.
    history_result_t history_results_due [$];

    int  errors       = 0;
    int  n_samples    = 0;
    int  n_checks     = 0;
    int  n_drains     = 0;
    int  n_ignored    = 0;
    int  n_compared   = 0;
    int  n_writes     = 0;
    int  idle_cycles  = 0;
    bit  hold_off_req = 1'b0;

    sound_level_event_history i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .raw_sample    (raw_sample),
        .target_event  (target_event),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sound_level   (sound_level),
        .current_event (current_event),
        .event_found   (event_found),
        .drained_event (drained_event),
        .last_item     (last_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_history();
        foreach (hist_store[i])
            hist_store[i] = EV_NONE;
        hist_count = 0;
    endfunction

    // A push equal to the newest entry is dropped; a full history loses its
    // oldest entry to make room.
    function automatic void push_event(logic [EVENT_W-1:0] ev);
        if (hist_count > 0 && hist_store[hist_count-1] == ev)
            return;
        if (hist_count == DEF_HISTORY_DEPTH)
        begin
            for (int i = 1; i < DEF_HISTORY_DEPTH; i++)
                hist_store[i-1] = hist_store[i];
            hist_store[DEF_HISTORY_DEPTH-1] = ev;
        end
        else
        begin
            hist_store[hist_count] = ev;
            hist_count++;
        end
    endfunction

    // Advances the shadow history by one accepted transaction and, unless the
    // caller supplies the result itself, queues what the block should return.
    function automatic void apply_history_op(logic [OP_W-1:0] op, logic [RAW_W-1:0] raw,
                                             logic [EVENT_W-1:0] tgt, bit queue_results);
        history_result_t res;
        int              level;
        res = '0;
        res.last = 1'b1;
        case (op)
            OP_SAMPLE:
            begin
                level = (int'(raw) * LEVEL_MAX) / ADC_FULL_SCALE;
                // With overlapping thresholds quiet goes in ahead of loud.
                if (level < int'(quiet_thr))
                    push_event(EV_QUIET);
                if (level > int'(loud_thr))
                    push_event(EV_LOUD);
                res.level = level[LEVEL_W-1:0];
                res.cur_event = (hist_count > 0) ? hist_store[hist_count-1] : EV_NONE;
                if (queue_results)
                    history_results_due.push_back(res);
                n_samples++;
            end
            OP_CHECK:
            begin
                // Asking for none really asks whether there is room left.
                if (tgt == EV_NONE)
                    res.found = (hist_count < DEF_HISTORY_DEPTH);
                else if (tgt == EV_QUIET || tgt == EV_LOUD)
                    for (int i = 0; i < hist_count; i++)
                        if (hist_store[i] == tgt)
                            res.found = 1'b1;
                if (queue_results)
                    history_results_due.push_back(res);
                clear_history();
                n_checks++;
            end
            OP_DRAIN:
            begin
                if (hist_count == 0)
                begin
                    if (queue_results)
                        history_results_due.push_back(res);
                end
                else
                begin
                    for (int i = 0; i < hist_count; i++)
                    begin
                        res.drained = hist_store[i];
                        res.last = (i == hist_count - 1);
                        if (queue_results)
                            history_results_due.push_back(res);
                    end
                end
                clear_history();
                n_drains++;
            end
            default:
                n_ignored++;
        endcase
    endfunction

    // Readings are drawn from the extremes, from a narrow band around one of
    // the current thresholds, or from anywhere on the ADC scale.
    function automatic logic [RAW_W-1:0] draw_raw();
        int r;
        int base;
        int v;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 3))
                0:       v = 0;
                1:       v = ADC_FULL_SCALE;
                2:       v = 1;
                default: v = ADC_FULL_SCALE - 1;
            endcase
        end
        else if (r < 45)
        begin
            base = (int'($urandom_range(0, 1) ? quiet_thr : loud_thr) * ADC_FULL_SCALE)
                   / LEVEL_MAX;
            v = base + int'($urandom_range(0, 96)) - 48;
            if (v < 0)
                v = 0;
            if (v > ADC_FULL_SCALE)
                v = ADC_FULL_SCALE;
        end
        else
            v = $urandom_range(0, ADC_FULL_SCALE);
        return v[RAW_W-1:0];
    endfunction

    // Sender gaps: mostly back to back, often a short pause, now and
    // then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one input transaction and holds it until the block takes it.
    // The shadow model is advanced at the edge where the handshake happens.
    // valid is only lowered when a gap follows, so a back-to-back item never
    // sees valid dropped and raised within the same time step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                             input logic [EVENT_W-1:0] tgt, input bit typed,
                             input history_result_t typed_res);
        int gap;
        in_valid     <= 1'b1;
        operation    <= op;
        raw_sample   <= raw;
        target_event <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_history_op(op, raw, tgt, !typed);
        if (typed)
            history_results_due.push_back(typed_res);
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Brings the block to rest: everything owed has arrived, and an ignored
    // operation code, which owes nothing, has had time to pass through.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (history_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // APB write: a setup cycle, then an access cycle that completes on the
    // edge at which pready is seen high, then the bus goes idle so
    // that a following write starts cleanly.
    task automatic write_threshold(input logic [CFG_ADDR_W-1:0] addr,
                                   input logic [LEVEL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_QUIET)
            quiet_thr = value;
        else if (addr == ADDR_LOUD)
            loud_thr = value;
        n_writes++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // The receiver's stall pattern: free-running stretches, short stalls and
    // the odd long one. Once, on request, it holds off for a long stretch
    // while the sender keeps offering, so that the block backs up into its
    // input.
    initial
    begin : receiver
        int  r;
        int  run;
        bit  held_off;
        held_off = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req && !held_off)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(1, 24);
                end
                else if (r < 92)
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(10, 40);
                end
                repeat (run)
                    @(posedge clk);
            end
        end
    end

    // Output side. Values are read at the edge itself, before any of this
    // edge's updates land, so the handshake and payload are those the block
    // presented during the cycle that just ended.
    always @(posedge clk)
    begin : result_checker
        history_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (history_results_due.size() == 0)
            begin
                $display("%0t: result transaction with nothing outstanding (level %0d)",
                         $time, sound_level);
                errors++;
            end
            else
            begin
                want = history_results_due.pop_front();
                compare_field("sound_level", want.level, sound_level);
                compare_field("current_event", 8'(want.cur_event), 8'(current_event));
                compare_field("event_found", 8'(want.found), 8'(event_found));
                compare_field("drained_event", 8'(want.drained), 8'(drained_event));
                compare_field("last_item", 8'(want.last), 8'(last_item));
                n_compared++;
            end
        end
    end

    // Watchdog: any transaction on either channel or the register port
    // restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, history_results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t          row;
        history_result_t    typed_res;
        logic [EVENT_W-1:0] tgt_pick;
        int                 items;
        int                 burst;
        int                 r;
        clear_history();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan. Register rows wait for the block to go idle first.
        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_WRITE)
            begin
                settle_block();
                write_threshold(row.addr, row.wdata);
            end
            else
            begin
                typed_res = '{level: row.lvl, cur_event: row.cur, found: row.found,
                              drained: row.drained, last: 1'b1};
                send_item(row.op, row.raw, row.tgt, row.typed, typed_res);
            end
        end

        // Random phases. Most traffic is a burst of samples closed by a check
        // or a drain, so the history regularly fills and wraps; a burst of
        // length zero gives back-to-back checks and drains on a short or
        // empty history, and the unused code is thrown in now and then.
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            settle_block();
            write_threshold(ADDR_QUIET, PHASE_QUIET[phase]);
            write_threshold(ADDR_LOUD, PHASE_LOUD[phase]);
            if (phase == 1)
                hold_off_req = 1'b1;
            items = 0;
            while (items < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(0, 8);
                repeat (burst)
                begin
                    tgt_pick = EVENT_W'($urandom_range(0, 3));
                    send_item(OP_SAMPLE, draw_raw(), tgt_pick, 1'b0, '0);
                    items++;
                end
                tgt_pick = EVENT_W'($urandom_range(0, 3));
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    send_item(OP_CHECK, draw_raw(), tgt_pick, 1'b0, '0);
                    items++;
                end
                else if (r < 93)
                begin
                    send_item(OP_DRAIN, draw_raw(), tgt_pick, 1'b0, '0);
                    items++;
                end
                else
                    send_item(OP_UNUSED, draw_raw(), tgt_pick, 1'b0, '0);
            end
        end

        settle_block();
        if (history_results_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, history_results_due.size());
            errors += history_results_due.size();
        end

        $display("Ran %0d samples, %0d checks, %0d drains and %0d unused codes over %0d writes",
                 n_samples, n_checks, n_drains, n_ignored, n_writes);
        $display("to the thresholds; %0d result transactions compared, %0d errors.",
                 n_compared, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sound_level_event_history.f
rtl/core/slh_pkg.sv
rtl/core/slh_ctrl.sv
rtl/core/slh_dp.sv
rtl/core/sound_level_event_history.sv
dv/testbench.sv
